>>> rtl/sha256_pkg.sv
// ============================================================================
// SHA-256 digest unit package
// Shared types, round constants and helper functions for the digest unit.
// ============================================================================
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PAD,
        ST_ZERO,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Block word positions of the 64-bit message length.
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

>>> rtl/sha256_message_digest_unit.sv
// ============================================================================
// SHA-256 message digest unit
// Streams a message in byte by byte and returns its SHA-256 digest.
// ============================================================================
// One input word carries one message byte (or an empty end marker) and a last
// flag. Bytes are accepted one per cycle while a block is being collected;
// every fourth byte writes a complete big-endian word into a 16-word block
// memory. The byte that completes a 64-byte block starts a compression that
// holds o_ready low: 16 rounds of a read and then an update, 48 rounds of
// four schedule reads and then the update with the new schedule word written
// back in place of the oldest one, and a final step that adds the working
// words into the chain words. After a last word the unit places the 0x80
// byte, writes zeros and the bit length into the remaining block words, and
// runs one compression; when 56 or more bytes were in the final partial
// block a second all-zero block with the length follows (16 word writes and
// another compression). It then offers the eight digest words, word 0 first,
// the eighth marked last, and returns to its reset state for the next
// message. Every block word is written before it is read, so the memory
// needs no clearing pass.
module sha256_message_digest_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sha256_pkg::t_in_word  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sha256_pkg::t_out_word o_data
);

    // Block memory: holds the block, then serves as the schedule ring.
    logic [31:0] r_mem [16];
    logic [31:0] r_rd;
    logic [3:0]  rd_addr;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic        wr_en;

    // Chain words, working words and control.
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    sha256_pkg::t_state r_state, n_state;
    logic [5:0]  r_t;
    logic [2:0]  r_sub;
    logic [31:0] r_acc;
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [31:0] r_word;
    logic [3:0]  r_widx;
    logic        r_final;
    logic        r_padded;
    logic        r_tail;
    logic [2:0]  r_cnt;

    logic        accept;
    logic        take_byte;
    logic        sched_step;
    logic        round_done;
    logic [4:0]  sh;
    logic [31:0] merged;
    logic [31:0] pad_word;
    logic [31:0] w_cur;
    logic [31:0] t1;
    logic [31:0] t2;

    assign accept     = i_valid && o_ready;
    assign take_byte  = accept && i_data.byte_valid;
    assign sched_step = (r_t[5:4] != 2'd0);
    assign round_done = (r_state == sha256_pkg::ST_ROUND)
                        && (sched_step ? (r_sub == 3'd4) : (r_sub == 3'd1));

    // Byte placement into the partial block word.
    always_comb begin
        sh       = 5'(5'd24 - {r_fill[1:0], 3'b000});
        merged   = r_word | ({24'd0, i_data.data_byte} << sh);
        pad_word = r_word | ({24'd0, sha256_pkg::PAD_BYTE} << sh);
    end

    // One SHA-256 round on the working words.
    always_comb begin
        w_cur = sched_step ? 32'(r_acc + r_rd) : r_rd;
        t1 = 32'(r_v[7] + sha256_pkg::big_sigma1(r_v[4])
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha256_pkg::ROUND_K[r_t] + w_cur);
        t2 = 32'(sha256_pkg::big_sigma0(r_v[0])
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2])));
    end

    // Memory addresses and write data.
    always_comb begin
        rd_addr = '0;
        wr_addr = '0;
        wr_data = '0;
        wr_en   = 1'b0;
        unique case (r_state)
            sha256_pkg::ST_LOAD: begin
                if (take_byte && r_fill[1:0] == 2'd3) begin
                    wr_en   = 1'b1;
                    wr_addr = r_fill[5:2];
                    wr_data = merged;
                end
            end
            sha256_pkg::ST_PAD: begin
                wr_en   = 1'b1;
                wr_addr = r_fill[5:2];
                wr_data = pad_word;
            end
            sha256_pkg::ST_ZERO: begin
                wr_en   = 1'b1;
                wr_addr = r_widx;
                if (r_tail && r_widx == sha256_pkg::LEN_HI_IDX) begin
                    wr_data = r_bits[63:32];
                end else if (r_tail && r_widx == sha256_pkg::LEN_LO_IDX) begin
                    wr_data = r_bits[31:0];
                end
            end
            sha256_pkg::ST_ROUND: begin
                // Schedule operands t-2, t-7, t-15 and t-16 modulo 16.
                unique case (r_sub)
                    3'd0: rd_addr = sched_step ? 4'(r_t - 6'd2) : r_t[3:0];
                    3'd1: rd_addr = 4'(r_t - 6'd7);
                    3'd2: rd_addr = 4'(r_t - 6'd15);
                    3'd3: rd_addr = r_t[3:0];
                    default: ;
                endcase
                if (sched_step && r_sub == 3'd4) begin
                    wr_en   = 1'b1;
                    wr_addr = r_t[3:0];
                    wr_data = w_cur;
                end
            end
            default: ;
        endcase
    end

    // Memory port with a registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_LOAD: begin
                if (accept) begin
                    if (i_data.byte_valid && r_fill == 6'd63) begin
                        n_state = sha256_pkg::ST_ROUND;
                    end else if (i_data.last) begin
                        n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                n_state = (r_fill[5:2] == 4'd15) ? sha256_pkg::ST_ROUND : sha256_pkg::ST_ZERO;
            end
            sha256_pkg::ST_ZERO: begin
                if (r_widx == 4'd15) begin
                    n_state = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (round_done && r_t == 6'd63) begin
                    n_state = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD: begin
                priority if (r_tail) begin
                    n_state = sha256_pkg::ST_EMIT;
                end else if (r_padded) begin
                    n_state = sha256_pkg::ST_ZERO;
                end else if (r_final) begin
                    n_state = sha256_pkg::ST_PAD;
                end else begin
                    n_state = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_EMIT: begin
                if (i_ready && r_cnt == 3'd7) begin
                    n_state = sha256_pkg::ST_LOAD;
                end
            end
            default: n_state = sha256_pkg::ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready = (r_state == sha256_pkg::ST_LOAD);
        o_valid = (r_state == sha256_pkg::ST_EMIT);
        o_data.digest_word = r_h[r_cnt];
        o_data.digest_last = (r_cnt == 3'd7);
    end

    // Datapath and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha256_pkg::ST_LOAD;
            r_t      <= '0;
            r_sub    <= '0;
            r_fill   <= '0;
            r_bits   <= '0;
            r_word   <= '0;
            r_widx   <= '0;
            r_final  <= 1'b0;
            r_padded <= 1'b0;
            r_tail   <= 1'b0;
            r_cnt    <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::INIT_H[i];
            end
        end else begin
            r_state <= n_state;
            // Start of a compression: load the working words.
            if (n_state == sha256_pkg::ST_ROUND && r_state != sha256_pkg::ST_ROUND) begin
                r_t   <= '0;
                r_sub <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            unique case (r_state)
                sha256_pkg::ST_LOAD: begin
                    if (accept) begin
                        r_final <= i_data.last;
                        if (i_data.byte_valid) begin
                            r_fill <= 6'(r_fill + 6'd1);
                            r_bits <= 64'(r_bits + 64'd8);
                            r_word <= (r_fill[1:0] == 2'd3) ? '0 : merged;
                        end
                    end
                end
                sha256_pkg::ST_PAD: begin
                    // Length fits in this block when the pad byte lands before byte 56.
                    r_padded <= 1'b1;
                    r_tail   <= (r_fill <= 6'd55);
                    r_widx   <= 4'(r_fill[5:2] + 4'd1);
                    r_word   <= '0;
                end
                sha256_pkg::ST_ZERO: begin
                    r_widx <= 4'(r_widx + 4'd1);
                end
                sha256_pkg::ST_ROUND: begin
                    if (round_done) begin
                        r_v[7] <= r_v[6];
                        r_v[6] <= r_v[5];
                        r_v[5] <= r_v[4];
                        r_v[4] <= 32'(r_v[3] + t1);
                        r_v[3] <= r_v[2];
                        r_v[2] <= r_v[1];
                        r_v[1] <= r_v[0];
                        r_v[0] <= 32'(t1 + t2);
                        r_t    <= 6'(r_t + 6'd1);
                        r_sub  <= '0;
                    end else begin
                        r_sub <= 3'(r_sub + 3'd1);
                    end
                    // Schedule word accumulation as operands arrive.
                    unique case (r_sub)
                        3'd1: r_acc <= sha256_pkg::small_sigma1(r_rd);
                        3'd2: r_acc <= 32'(r_acc + r_rd);
                        3'd3: r_acc <= 32'(r_acc + sha256_pkg::small_sigma0(r_rd));
                        default: ;
                    endcase
                end
                sha256_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= 32'(r_h[i] + r_v[i]);
                    end
                    // A spilled pad needs one more block of zeros and the length.
                    if (r_padded && !r_tail) begin
                        r_widx <= '0;
                        r_tail <= 1'b1;
                    end
                end
                sha256_pkg::ST_EMIT: begin
                    if (i_ready) begin
                        r_cnt <= 3'(r_cnt + 3'd1);
                        if (r_cnt == 3'd7) begin
                            r_fill   <= '0;
                            r_bits   <= '0;
                            r_word   <= '0;
                            r_final  <= 1'b0;
                            r_padded <= 1'b0;
                            r_tail   <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha256_pkg::INIT_H[i];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
